// ===== rtl/acs_pkg.sv =====
// Shared types, constants and tone tables for the alarm and chime sequencer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package acs_pkg;

  localparam int SLOT_COUNT    = 8;
  localparam int MELODY_LENGTH = 10;
  localparam int SLOT_REGS     = 4;
  localparam int TIME_W        = 17;
  localparam int STAMP_W       = 33;
  localparam int DAY_W         = 16;
  localparam int HOUR_Q_W      = 6;
  localparam int FREQ_W        = 12;
  localparam int DUR_W         = 10;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_ADDR_W    = 6;

  localparam logic [STAMP_W-1:0] SECS_PER_DAY   = 33'd86400;
  // Hour estimate: (second_of_day >> 4) / 225 as a multiply by 2^21/225.
  localparam logic [13:0]        HOUR_RECIP     = 14'd9321;
  localparam int                 HOUR_SHIFT     = 21;
  localparam logic [7:0]         HOUR_DIV16     = 8'd225;
  localparam logic [DUR_W-1:0]   CHIME_DURATION = 10'd75;
  localparam logic [FREQ_W-1:0]  REST_FREQ      = 12'd1;
  localparam logic [FREQ_W-1:0]  CHIME_FREQ_LO  = 12'd1175;
  localparam logic [FREQ_W-1:0]  CHIME_FREQ_HI  = 12'd1760;
  localparam logic [4:0]         NO_HOUR        = 5'd25;

  typedef enum logic [2:0] {
    REG_ALARM_ENABLES = 3'd0,
    REG_HOURLY_CHIME  = 3'd1,
    REG_TWELVE_HOUR   = 3'd2,
    REG_SLOT_TIMES_01 = 3'd3,
    REG_SLOT_TIMES_23 = 3'd4,
    REG_SLOT_TIMES_45 = 3'd5,
    REG_SLOT_TIMES_67 = 3'd6
  } acs_reg_t;

  typedef struct packed {
    logic [SLOT_COUNT-1:0]               alarm_enables;
    logic                                hourly_chime_on;
    logic                                twelve_hour_mode;
    logic [SLOT_REGS-1:0][2*TIME_W-1:0]  slot_times;
  } acs_cfg_t;

  typedef struct packed {
    logic                 action;
    logic                 clock_valid;
    logic                 tone_ready;
    logic [TIME_W-1:0]    second_of_day;
    logic [HOUR_Q_W-1:0]  hour_q;
    logic [STAMP_W-1:0]   day_base;
    logic [STAMP_W-1:0]   now;
  } acs_item_t;

  typedef struct packed {
    logic                  tone_valid;
    logic [FREQ_W-1:0]     tone_frequency;
    logic [DUR_W-1:0]      tone_duration;
    logic [SLOT_COUNT-1:0] alarms_active;
  } acs_result_t;

  function automatic logic [FREQ_W-1:0] melody_freq(input logic [4:0] idx);
    logic [FREQ_W-1:0] f;
    case (idx)
      5'd0:    f = 12'd2093;
      5'd1:    f = 12'd1568;
      5'd2:    f = 12'd1;
      5'd3:    f = 12'd1568;
      5'd4:    f = 12'd1760;
      5'd5:    f = 12'd1568;
      5'd6:    f = 12'd1;
      5'd7:    f = 12'd1976;
      5'd8:    f = 12'd2093;
      5'd9:    f = 12'd1;
      default: f = '0;
    endcase
    return f;
  endfunction

  function automatic logic [DUR_W-1:0] melody_dur(input logic [4:0] idx);
    logic [DUR_W-1:0] d;
    case (idx)
      5'd0:    d = 10'd150;
      5'd1:    d = 10'd300;
      5'd2:    d = 10'd50;
      5'd3:    d = 10'd300;
      5'd4:    d = 10'd150;
      5'd5:    d = 10'd150;
      5'd6:    d = 10'd150;
      5'd7:    d = 10'd150;
      5'd8:    d = 10'd150;
      5'd9:    d = 10'd700;
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/alarm_and_binary_chime_sequencer.sv =====
// Alarm and binary hourly-chime sequencer, top level: ports, handshakes, result register.
// Path from input transfer to result valid: input stage, then result register.
// Throughput: one item per cycle while out_stall is low; sole loop: the acs_core state update.
// Reset (synchronous, rst_n low): state registers cleared, start-up chime set pending.
// Depends on acs_pkg, acs_cfg, acs_prep and acs_core.
`default_nettype none

module alarm_and_binary_chime_sequencer (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input channel.
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_action,
  input  wire logic                              in_clock_valid,
  input  wire logic [acs_pkg::DAY_W-1:0]         in_day_number,
  input  wire logic [acs_pkg::TIME_W-1:0]        in_second_of_day,
  input  wire logic                              in_tone_ready,
  // Result channel.
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_tone_valid,
  output logic      [acs_pkg::FREQ_W-1:0]        out_tone_frequency,
  output logic      [acs_pkg::DUR_W-1:0]         out_tone_duration,
  output logic      [acs_pkg::SLOT_COUNT-1:0]    out_alarms_active,
  // Configuration port.
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [acs_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [acs_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic      [acs_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                   cfg_pready
);
  import acs_pkg::*;

  acs_cfg_t    cfg;
  acs_item_t   item;
  acs_result_t res;
  acs_result_t res_r;
  logic        item_valid;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;
  logic        fire;
  logic        in_take;

  // The result register is free when empty or when its transfer completes
  // this cycle. The input stage hands its item to the core exactly then, so
  // a new input transfer can land in the same cycle and items flow at one
  // per cycle with no bubble while out_stall stays low.
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = item_valid && out_free;
  assign in_stall = item_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  acs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Input stage: holds the accepted item together with its time stamp and
  // raw hour, so the core does not repeat the day-base and hour-estimate multiplies.
  acs_prep u_prep (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (in_take),
    .drain         (fire),
    .action        (in_action),
    .clock_valid   (in_clock_valid),
    .day_number    (in_day_number),
    .second_of_day (in_second_of_day),
    .tone_ready    (in_tone_ready),
    .item_valid    (item_valid),
    .item          (item)
  );

  // Core: updates the alarm, melody and chime state at the edge where the
  // item's result is written into the result register.
  acs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_valid_nxt = fire || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_tone_valid     = res_r.tone_valid;
  assign out_tone_frequency = res_r.tone_frequency;
  assign out_tone_duration  = res_r.tone_duration;
  assign out_alarms_active  = res_r.alarms_active;

`ifndef SYNTH
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> item_valid)
    else $error("input stalled with an empty input stage");

  a_silent_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_tone_valid) |-> (out_tone_frequency == '0 && out_tone_duration == '0))
    else $error("result without a tone carries a frequency or duration");

  a_tone_has_freq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_tone_valid) |-> (out_tone_frequency != '0 && out_tone_duration != '0))
    else $error("tone request with zero frequency or duration");
`endif

endmodule

`default_nettype wire

// ===== rtl/acs_cfg.sv =====
// Configuration register file with an APB-style access port.
// Depends on acs_pkg for register codes and the configuration struct.
`default_nettype none

module acs_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [acs_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [acs_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [acs_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                   pready,
  output acs_pkg::acs_cfg_t                      cfg
);
  import acs_pkg::*;

  acs_cfg_t cfg_r;
  acs_reg_t reg_sel;
  logic     wr_en;

  assign reg_sel = acs_reg_t'(paddr[CFG_ADDR_W-1:3]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_ALARM_ENABLES: cfg_r.alarm_enables    <= pwdata[SLOT_COUNT-1:0];
        REG_HOURLY_CHIME:  cfg_r.hourly_chime_on  <= pwdata[0];
        REG_TWELVE_HOUR:   cfg_r.twelve_hour_mode <= pwdata[0];
        REG_SLOT_TIMES_01: cfg_r.slot_times[0]    <= pwdata[2*TIME_W-1:0];
        REG_SLOT_TIMES_23: cfg_r.slot_times[1]    <= pwdata[2*TIME_W-1:0];
        REG_SLOT_TIMES_45: cfg_r.slot_times[2]    <= pwdata[2*TIME_W-1:0];
        REG_SLOT_TIMES_67: cfg_r.slot_times[3]    <= pwdata[2*TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ALARM_ENABLES: prdata = CFG_DATA_W'(cfg_r.alarm_enables);
      REG_HOURLY_CHIME:  prdata = CFG_DATA_W'(cfg_r.hourly_chime_on);
      REG_TWELVE_HOUR:   prdata = CFG_DATA_W'(cfg_r.twelve_hour_mode);
      REG_SLOT_TIMES_01: prdata = CFG_DATA_W'(cfg_r.slot_times[0]);
      REG_SLOT_TIMES_23: prdata = CFG_DATA_W'(cfg_r.slot_times[1]);
      REG_SLOT_TIMES_45: prdata = CFG_DATA_W'(cfg_r.slot_times[2]);
      REG_SLOT_TIMES_67: prdata = CFG_DATA_W'(cfg_r.slot_times[3]);
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/acs_prep.sv =====
// Input register stage: captures one item and precomputes the day base,
// the time stamp and the raw hour. Depends on acs_pkg.
`default_nettype none

module acs_prep (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load,
  input  wire logic                          drain,
  input  wire logic                          action,
  input  wire logic                          clock_valid,
  input  wire logic [acs_pkg::DAY_W-1:0]     day_number,
  input  wire logic [acs_pkg::TIME_W-1:0]    second_of_day,
  input  wire logic                          tone_ready,
  output logic                               item_valid,
  output acs_pkg::acs_item_t                 item
);
  import acs_pkg::*;

  logic               valid_r, valid_nxt;
  acs_item_t          item_r, item_nxt;
  logic [STAMP_W-1:0] day_base;
  logic [26:0]        hour_prod;

  // The day base never exceeds 33 bits, so the stamp needs no masking.
  assign day_base  = STAMP_W'(day_number) * SECS_PER_DAY;
  assign hour_prod = 27'(second_of_day[TIME_W-1:4]) * 27'(HOUR_RECIP);

  always_comb begin
    item_nxt               = item_r;
    item_nxt.action        = action;
    item_nxt.clock_valid   = clock_valid;
    item_nxt.tone_ready    = tone_ready;
    item_nxt.second_of_day = second_of_day;
    item_nxt.hour_q        = hour_prod[HOUR_SHIFT +: HOUR_Q_W];
    item_nxt.day_base      = day_base;
    item_nxt.now           = day_base + STAMP_W'(second_of_day);
    if (load) begin
      valid_nxt = 1'b1;
    end else if (drain) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ===== rtl/acs_core.sv =====
// Sequencer state and the per-item decision logic: alarm detection,
// melody stepping, binary hourly chime and acknowledge. Depends on acs_pkg.
`default_nettype none

module acs_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire acs_pkg::acs_item_t item,
  input  wire acs_pkg::acs_cfg_t  cfg,
  output acs_pkg::acs_result_t    res
);
  import acs_pkg::*;

  localparam logic [7:0] MELODY_LEN8 = 8'(MELODY_LENGTH);

  logic [7:0]                          beep_r, beep_nxt;
  logic [SLOT_COUNT-1:0]               mask_r, mask_nxt;
  logic                                pend_r, pend_nxt;
  logic [4:0]                          last_r, last_nxt;
  logic [SLOT_COUNT-1:0][STAMP_W-1:0]  stamps_r, stamps_nxt;

  logic [SLOT_COUNT-1:0] hit;
  logic                  top_of_hour;
  logic [13:0]           hour_check;
  logic [4:0]            hour24, hour12, hour_sel, hour_bits;
  logic [7:0]            mel_idx;

  // Each enabled slot whose time has passed today raises its alarm unless
  // its acknowledge stamp is at or past today's due time.
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      logic [TIME_W-1:0]  t;
      logic [STAMP_W-1:0] due;
      t      = cfg.slot_times[i/2][(i%2)*TIME_W +: TIME_W];
      due    = item.day_base + STAMP_W'(t);
      hit[i] = cfg.alarm_enables[i] && (item.second_of_day >= t) && (stamps_r[i] < due);
    end
  end

  assign hour_check  = 14'(item.hour_q) * 14'(HOUR_DIV16);
  assign top_of_hour = (item.second_of_day[3:0] == 4'd0) &&
                       (hour_check == 14'(item.second_of_day[TIME_W-1:4]));
  assign hour24      = (item.hour_q >= 6'd24) ? 5'(item.hour_q - 6'd24) : 5'(item.hour_q);
  assign hour12      = (hour24 >= 5'd12) ? (hour24 - 5'd12) : hour24;
  assign hour_sel    = !cfg.twelve_hour_mode ? hour24 :
                       ((hour12 == 5'd0) ? 5'd12 : hour12);
  // Bits of the hour still to be spelled; zero once the shift runs past them.
  assign hour_bits   = (beep_r[7:4] == 4'd0) ? (hour_sel >> beep_r[3:1]) : 5'd0;
  assign mel_idx     = (beep_r >= MELODY_LEN8) ? 8'd0 : beep_r;

  always_comb begin
    beep_nxt   = beep_r;
    mask_nxt   = mask_r;
    pend_nxt   = pend_r;
    last_nxt   = last_r;
    stamps_nxt = stamps_r;
    res        = '0;
    if (item.action) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (mask_r[i]) begin
          stamps_nxt[i] = item.now;
        end
      end
      mask_nxt = '0;
      beep_nxt = '0;
    end else if (item.clock_valid) begin
      if (cfg.hourly_chime_on && top_of_hour) begin
        pend_nxt = 1'b1;
      end
      mask_nxt = mask_r | hit;
      if (mask_nxt != '0) begin
        pend_nxt           = 1'b0;
        res.tone_valid     = 1'b1;
        res.tone_frequency = melody_freq(mel_idx[4:0]);
        res.tone_duration  = melody_dur(mel_idx[4:0]);
        beep_nxt           = item.tone_ready ? (mel_idx + 8'd1) : mel_idx;
      end else if (pend_nxt) begin
        if (hour_sel == last_r) begin
          pend_nxt = 1'b0;
        end else if (hour_sel == 5'd0) begin
          // Midnight gets one low beep, taken or not.
          res.tone_valid     = 1'b1;
          res.tone_frequency = CHIME_FREQ_LO;
          res.tone_duration  = CHIME_DURATION;
          beep_nxt           = '0;
          last_nxt           = 5'd0;
          pend_nxt           = 1'b0;
        end else if (hour_bits != 5'd0) begin
          res.tone_valid     = 1'b1;
          res.tone_duration  = CHIME_DURATION;
          if (!beep_r[0]) begin
            res.tone_frequency = hour_bits[0] ? CHIME_FREQ_HI : CHIME_FREQ_LO;
          end else begin
            res.tone_frequency = REST_FREQ;
          end
          if (item.tone_ready) begin
            beep_nxt = beep_r + 8'd1;
          end
        end else begin
          beep_nxt = '0;
          last_nxt = hour_sel;
          pend_nxt = 1'b0;
        end
      end
    end
    res.alarms_active = mask_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beep_r   <= '0;
      mask_r   <= '0;
      pend_r   <= 1'b1;
      last_r   <= NO_HOUR;
      stamps_r <= '0;
    end else if (fire) begin
      beep_r   <= beep_nxt;
      mask_r   <= mask_nxt;
      pend_r   <= pend_nxt;
      last_r   <= last_nxt;
      stamps_r <= stamps_nxt;
    end
  end

`ifndef SYNTH
  a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.action) |=> (mask_r == '0 && beep_r == '0))
    else $error("acknowledge did not clear alarms and melody position");

  a_bad_clock_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !item.action && !item.clock_valid) |=>
      ($stable(mask_r) && $stable(beep_r) && $stable(last_r) && $stable(pend_r)))
    else $error("tick with invalid clock changed sequencer state");

  a_alarm_kills_chime: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.alarms_active != '0) |=> !pend_r)
    else $error("chime still pending while an alarm sounds");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_alarm_and_binary_chime_sequencer.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for alarm_and_binary_chime_sequencer: a scoreboard class that
// predicts every tone request, plus the clock, reset, bus and handshake drivers.
// Depends only on acs_pkg and the RTL of the block.

import acs_pkg::*;

localparam logic [FREQ_W-1:0] TUNE_HZ [MELODY_LENGTH] =
  '{12'd2093, 12'd1568, 12'd1, 12'd1568, 12'd1760, 12'd1568, 12'd1, 12'd1976, 12'd2093, 12'd1};
localparam logic [DUR_W-1:0]  TUNE_MS [MELODY_LENGTH] =
  '{10'd150, 10'd300, 10'd50, 10'd300, 10'd150, 10'd150, 10'd150, 10'd150, 10'd150, 10'd700};

typedef struct packed {
  logic              action;
  logic              clock_valid;
  logic [DAY_W-1:0]  day_number;
  logic [TIME_W-1:0] second_of_day;
  logic              tone_ready;
} chime_input_t;

class chime_scoreboard;
  logic [SLOT_COUNT-1:0]  enables;
  logic                   chime_on;
  logic                   twelve_hr;
  logic [2*TIME_W-1:0]    slot_pairs [SLOT_REGS];

  logic [7:0]             beep_idx;
  logic [SLOT_COUNT-1:0]  sounding;
  logic                   chime_due;
  logic [4:0]             last_hour;
  logic [STAMP_W-1:0]     ack_stamp [SLOT_COUNT];

  acs_result_t            tone_requests_q [$];
  int unsigned            mismatches;

  function new();
    enables   = '0;
    chime_on  = 1'b0;
    twelve_hr = 1'b0;
    foreach (slot_pairs[i]) slot_pairs[i] = '0;
    beep_idx  = '0;
    sounding  = '0;
    chime_due = 1'b1;
    last_hour = NO_HOUR;
    foreach (ack_stamp[i]) ack_stamp[i] = '0;
    mismatches = 0;
  endfunction

  function void load_reg(acs_reg_t idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_ALARM_ENABLES: enables   = value[SLOT_COUNT-1:0];
      REG_HOURLY_CHIME:  chime_on  = value[0];
      REG_TWELVE_HOUR:   twelve_hr = value[0];
      REG_SLOT_TIMES_01: slot_pairs[0] = value[2*TIME_W-1:0];
      REG_SLOT_TIMES_23: slot_pairs[1] = value[2*TIME_W-1:0];
      REG_SLOT_TIMES_45: slot_pairs[2] = value[2*TIME_W-1:0];
      REG_SLOT_TIMES_67: slot_pairs[3] = value[2*TIME_W-1:0];
      default: ;
    endcase
  endfunction

  function logic [TIME_W-1:0] slot_time(int unsigned slot);
    logic [2*TIME_W-1:0] pair;
    pair = slot_pairs[slot >> 1];
    return slot[0] ? pair[2*TIME_W-1:TIME_W] : pair[TIME_W-1:0];
  endfunction

  function int unsigned pending();
    return tone_requests_q.size();
  endfunction

  // Advances the predicted sequencer state by one accepted input and queues the
  // tone request (or silence) that it must produce.
  function void note_input(chime_input_t t);
    acs_result_t        req;
    logic [STAMP_W-1:0] stamp_now;
    logic [STAMP_W-1:0] due;
    logic [TIME_W-1:0]  st;
    int unsigned        hr;
    int unsigned        shift;
    int unsigned        bits;
    req = '0;
    stamp_now = STAMP_W'(64'(t.day_number) * 64'(SECS_PER_DAY) + 64'(t.second_of_day));
    if (t.action) begin
      for (int i = 0; i < SLOT_COUNT; i++)
        if (sounding[i]) ack_stamp[i] = stamp_now;
      sounding = '0;
      beep_idx = '0;
    end else if (t.clock_valid) begin
      if (chime_on && (t.second_of_day % 3600) == 0) chime_due = 1'b1;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        st = slot_time(i);
        if (enables[i] && t.second_of_day >= st) begin
          due = STAMP_W'(64'(t.day_number) * 64'(SECS_PER_DAY) + 64'(st));
          if (ack_stamp[i] < due) sounding[i] = 1'b1;
        end
      end
      if (sounding != '0) begin
        chime_due = 1'b0;
        if (beep_idx >= MELODY_LENGTH) beep_idx = '0;
        req.tone_valid     = 1'b1;
        req.tone_frequency = TUNE_HZ[beep_idx];
        req.tone_duration  = TUNE_MS[beep_idx];
        if (t.tone_ready) beep_idx = beep_idx + 8'd1;
      end else if (chime_due) begin
        hr = (int'(t.second_of_day) / 3600) % 24;
        if (twelve_hr) begin
          hr = hr % 12;
          if (hr == 0) hr = 12;
        end
        if (hr == last_hour) begin
          chime_due = 1'b0;
        end else if (hr == 0) begin
          req.tone_valid     = 1'b1;
          req.tone_frequency = CHIME_FREQ_LO;
          req.tone_duration  = CHIME_DURATION;
          beep_idx  = '0;
          last_hour = '0;
          chime_due = 1'b0;
        end else begin
          shift = beep_idx >> 1;
          bits  = (shift < 8) ? (hr >> shift) : 0;
          if (bits != 0) begin
            req.tone_valid     = 1'b1;
            req.tone_frequency = beep_idx[0] ? REST_FREQ
                                 : (bits[0] ? CHIME_FREQ_HI : CHIME_FREQ_LO);
            req.tone_duration  = CHIME_DURATION;
            if (t.tone_ready) beep_idx = beep_idx + 8'd1;
          end else begin
            beep_idx  = '0;
            last_hour = 5'(hr);
            chime_due = 1'b0;
          end
        end
      end
    end
    req.alarms_active = sounding;
    tone_requests_q.push_back(req);
  endfunction

  function void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function void check_result(acs_result_t got);
    acs_result_t want;
    if (tone_requests_q.size() == 0) begin
      $display("%0t: unexpected result, tone_valid %0d frequency %0d duration %0d alarms %0h",
               $time, got.tone_valid, got.tone_frequency, got.tone_duration, got.alarms_active);
      mismatches++;
    end else begin
      want = tone_requests_q.pop_front();
      compare_field("tone_valid", want.tone_valid, got.tone_valid);
      compare_field("tone_frequency", want.tone_frequency, got.tone_frequency);
      compare_field("tone_duration", want.tone_duration, got.tone_duration);
      compare_field("alarms_active", want.alarms_active, got.alarms_active);
    end
  endfunction
endclass

module tb_alarm_and_binary_chime_sequencer;

  // Cycles the receiver holds off in one go to back the block up, and the number of
  // cycles without any transfer after which the run is declared hung.
  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned IDLE_LIMIT     = 4000;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned ITEMS_PER_PHASE = 156;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic                   in_action;
  logic                   in_clock_valid;
  logic [DAY_W-1:0]       in_day_number;
  logic [TIME_W-1:0]      in_second_of_day;
  logic                   in_tone_ready;
  logic                   out_valid;
  logic                   out_stall;
  logic                   out_tone_valid;
  logic [FREQ_W-1:0]      out_tone_frequency;
  logic [DUR_W-1:0]       out_tone_duration;
  logic [SLOT_COUNT-1:0]  out_alarms_active;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_ADDR_W-1:0]  cfg_paddr;
  logic [CFG_DATA_W-1:0]  cfg_pwdata;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  chime_scoreboard        sb;
  acs_result_t            seen;
  int unsigned            idle_cycles = 0;

  // hold_req is shared by the stimulus and receiver processes and requests one long
  // hold-off; sender_steady says whether the sender currently offers items back to back.
  bit                     hold_req = 1'b0;
  bit                     sender_steady = 1'b0;

  // Wall clock that the random ticks follow, so that chimes and alarms play out.
  logic [DAY_W-1:0]       cur_day = '0;
  logic [TIME_W-1:0]      cur_sec = '0;

  alarm_and_binary_chime_sequencer DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_clock_valid     (in_clock_valid),
    .in_day_number      (in_day_number),
    .in_second_of_day   (in_second_of_day),
    .in_tone_ready      (in_tone_ready),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_tone_valid     (out_tone_valid),
    .out_tone_frequency (out_tone_frequency),
    .out_tone_duration  (out_tone_duration),
    .out_alarms_active  (out_alarms_active),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Idle lengths for both sides: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic chime_input_t tick_of(bit act, bit cv, int unsigned day,
                                          int unsigned sec, bit rdy);
    chime_input_t t;
    t.action        = act;
    t.clock_valid   = cv;
    t.day_number    = DAY_W'(day);
    t.second_of_day = TIME_W'(sec);
    t.tone_ready    = rdy;
    return t;
  endfunction

  // Random input that mostly follows a plausible wall clock: time often stands still
  // so that a chime or melody can play out, jumps to the top of an hour or to a slot
  // time, rolls into the next day, and now and then lands anywhere in the field range.
  function automatic chime_input_t next_tick();
    chime_input_t t;
    int unsigned  pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      // Time holds.
    end else if (pick < 75) begin
      cur_sec = cur_sec + TIME_W'($urandom_range(20, 1));
      if (cur_sec >= 86400) begin
        cur_sec = cur_sec - TIME_W'(86400);
        cur_day = cur_day + 1'b1;
      end
    end else if (pick < 84) begin
      // Tops of hours, a few of them past the end of the day.
      cur_sec = TIME_W'(($urandom_range(99) < 10 ? $urandom_range(36, 24)
                                                 : $urandom_range(23)) * 3600);
    end else if (pick < 90) begin
      cur_sec = sb.slot_time($urandom_range(SLOT_COUNT - 1)) + TIME_W'($urandom_range(2));
    end else if (pick < 95) begin
      cur_day = cur_day + 1'b1;
    end else begin
      cur_day = DAY_W'($urandom_range(65535));
      cur_sec = TIME_W'($urandom_range(131071));
    end
    t.action        = ($urandom_range(99) < 5);
    t.clock_valid   = ($urandom_range(99) < 94);
    t.day_number    = cur_day;
    t.second_of_day = cur_sec;
    t.tone_ready    = ($urandom_range(99) < 70);
    return t;
  endfunction

  function automatic logic [TIME_W-1:0] rand_slot_time();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 12) return '0;
    if (r < 20) return '1;
    if (r < 28) return TIME_W'(86399);
    if (r < 65) return TIME_W'((int'(cur_sec) + $urandom_range(600)) % 86400);
    return TIME_W'($urandom_range(86399));
  endfunction

  // One register write: setup cycle, then access cycle until pready, then a pause with
  // psel low so that psel never drops and rises within the same edge.
  task automatic apb_write(acs_reg_t idx, logic [CFG_DATA_W-1:0] value);
    logic ready_seen;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(negedge clk);
      ready_seen = cfg_pready;
      @(posedge clk);
    end while (ready_seen !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.load_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic program_cfg(logic [SLOT_COUNT-1:0] en, logic chime, logic twelve,
                             logic [SLOT_REGS-1:0][2*TIME_W-1:0] pairs);
    apb_write(REG_ALARM_ENABLES, CFG_DATA_W'(en));
    apb_write(REG_HOURLY_CHIME, CFG_DATA_W'(chime));
    apb_write(REG_TWELVE_HOUR, CFG_DATA_W'(twelve));
    apb_write(REG_SLOT_TIMES_01, CFG_DATA_W'(pairs[0]));
    apb_write(REG_SLOT_TIMES_23, CFG_DATA_W'(pairs[1]));
    apb_write(REG_SLOT_TIMES_45, CFG_DATA_W'(pairs[2]));
    apb_write(REG_SLOT_TIMES_67, CFG_DATA_W'(pairs[3]));
  endtask

  // Offers one item after an optional gap and holds it until the transfer. The
  // handshake is sampled on the falling edge, where every signal has settled, and
  // the transfer itself takes place at the following rising edge.
  task automatic send_tick(chime_input_t t);
    int unsigned gap;
    bit          accepted;
    gap = sender_steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_action        <= t.action;
    in_clock_valid   <= t.clock_valid;
    in_day_number    <= t.day_number;
    in_second_of_day <= t.second_of_day;
    in_tone_ready    <= t.tone_ready;
    accepted = 1'b0;
    while (!accepted) begin
      @(negedge clk);
      accepted = (in_stall === 1'b0);
      if (accepted) sb.note_input(t);
      @(posedge clk);
    end
  endtask

  // Stops offering and waits until every predicted result has been seen, then waits on
  // for the two-stage pipeline to go quiet before the registers change.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side: random stall bursts, long open stretches, and one long hold-off on
  // request that the receiver counts out on its own.
  initial begin : receiver
    int unsigned stall_left;
    int unsigned open_left;
    stall_left = 0;
    open_left  = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (open_left != 0) begin
        open_left--;
        out_stall <= 1'b0;
      end else begin
        open_left  = ($urandom_range(9) == 0) ? $urandom_range(300, 100) : $urandom_range(12);
        stall_left = pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  // Every result transfer is checked against the oldest prediction.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen = {out_tone_valid, out_tone_frequency, out_tone_duration, out_alarms_active};
      sb.check_result(seen);
    end
  end

  // Hang detection: too long without a transfer on either channel ends the run.
  always @(negedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_alarm_and_binary_chime_sequencer: errors");
      $finish;
    end
  end

  initial begin : stimulus
    logic [SLOT_REGS-1:0][2*TIME_W-1:0] pairs;
    logic [SLOT_COUNT-1:0]              en;
    logic                               chime;
    logic                               twelve;
    sb = new();
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_action        = 1'b0;
    in_clock_valid   = 1'b0;
    in_day_number    = '0;
    in_second_of_day = '0;
    in_tone_ready    = 1'b0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, first with the chime armed and no alarms. The block leaves reset
    // with a chime pending, so the first valid tick plays the start-up beep.
    program_cfg(8'h00, 1'b1, 1'b0, '0);
    send_tick(tick_of(0, 0, 65535, 131071, 1));   // tick with the clock not set
    send_tick(tick_of(1, 0, 0, 0, 0));            // acknowledge with the clock not set
    send_tick(tick_of(0, 1, 0, 0, 0));            // hour zero beep ends even when not taken
    send_tick(tick_of(0, 1, 0, 0, 1));            // same hour again: nothing to chime
    send_tick(tick_of(0, 1, 0, 3 * 3600, 0));     // hour three, tone generator busy
    repeat (5) send_tick(tick_of(0, 1, 0, 3 * 3600, 1));  // bits, rests, then the end
    // A second of day past midnight's range still chimes as its hour modulo 24.
    repeat (4) send_tick(tick_of(0, 1, 0, 36 * 3600, 1));
    drain();

    // Two alarm slots, one of them at the largest time the field can hold, and the
    // chime in twelve-hour form. The alarm interrupts the chime mid-sequence.
    pairs    = '1;
    pairs[0] = {17'd131071, 17'd100};
    program_cfg(8'h03, 1'b1, 1'b1, pairs);
    send_tick(tick_of(0, 1, 5, 100, 1));          // slot 0 due: melody starts
    send_tick(tick_of(0, 1, 5, 100, 0));          // melody held, generator busy
    send_tick(tick_of(1, 1, 5, 101, 1));          // acknowledge stamps slot 0
    send_tick(tick_of(0, 1, 5, 200, 1));          // acknowledged today: stays quiet
    send_tick(tick_of(0, 1, 6, 100, 1));          // next day: sounds again
    send_tick(tick_of(0, 1, 65535, 131071, 1));   // largest date and time
    send_tick(tick_of(1, 1, 65535, 131071, 0));
    send_tick(tick_of(0, 1, 65535, 0, 1));        // midnight chimes as twelve
    drain();

    // Random phases. The first two use the extreme settings; each phase starts from
    // an idle block, so the sender pauses for every result before the registers move.
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) begin
        en = '1; chime = 1'b1; twelve = 1'b1; pairs = '1;
      end else if (phase == 1) begin
        en = '0; chime = 1'b0; twelve = 1'b0; pairs = '0;
      end else begin
        en     = ($urandom_range(3) == 0) ? '1 : SLOT_COUNT'($urandom_range(255));
        chime  = ($urandom_range(3) != 0);
        twelve = $urandom_range(1);
        for (int i = 0; i < SLOT_REGS; i++)
          pairs[i] = {rand_slot_time(), rand_slot_time()};
      end
      program_cfg(en, chime, twelve, pairs);
      sender_steady = (phase == 3) || ($urandom_range(3) == 0);
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        // In one phase the receiver backs off for a long while as the sender keeps
        // offering, so the block fills and stalls its input.
        if (phase == 3 && n == 40) hold_req = 1'b1;
        send_tick(next_tick());
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.mismatches++;
    end
    if (sb.mismatches == 0)
      $display("tb_alarm_and_binary_chime_sequencer: clean");
    else
      $display("tb_alarm_and_binary_chime_sequencer: errors");
    $finish;
  end

endmodule
